// ===== rtl/cca_pkg.sv =====
// shared types and constants for the chunked cell allocator
`timescale 1ns / 1ps
package cca_pkg;
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RECYCLE = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;
    localparam logic [1:0] OP_SHRINK  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam int ID_W  = 12;
    localparam int REL_W = 35;

    // pool geometry, tied to the id and count field widths
    localparam int MAX_CHUNKS     = 16;
    localparam int MAX_CELLS_LOG2 = 8;
endpackage

// ===== rtl/chunked_cell_allocator_unit.sv =====
// top level of the chunked cell allocator: sequencer, chunk table and stack
// Use: one request word on s_axis (operation, cell id) gives one result word
// on m_axis (allocated id, status, used cells, live chunks, released bytes).
// A request is taken only while the unit is idle and no result waits.
// Steps from accept to result valid: allocate from stack waits for the
// stack read; recycle checks and pushes; bump allocate in the current
// chunk bumps; allocate with chunk scan walks the chunks for an open one,
// else an absent one, then bumps; reset all clears, then walks to the first
// present chunk; shrink walks the chunks and, when something is released,
// reads and writes back each stack entry. One word is handled at a time;
// the next request is taken the cycle after the result word leaves.
// Configuration writes go through cfg_wr_en / cfg_addr / cfg_data at any
// edge (only while idle by contract).
// Reset (aresetn low, synchronous) empties all chunks and the stack; no
// clearing pass is needed. When the receiver stalls the result is held in
// the output register and no new request is taken until it leaves.
`timescale 1ns / 1ps
module chunked_cell_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // operation[1:0], cell_id[13:2], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // allocated_id, status, used_cells,
                                        // live_chunks, released_bytes, zero
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_data
);
    localparam int MAX_CHUNKS     = cca_pkg::MAX_CHUNKS;
    localparam int MAX_CELLS_LOG2 = cca_pkg::MAX_CELLS_LOG2;
    localparam int CW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNW   = $clog2(MAX_CHUNKS + 1);
    localparam int DEPTH = MAX_CHUNKS << MAX_CELLS_LOG2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int BW    = MAX_CELLS_LOG2 + 1;
    localparam int SW    = $clog2(MAX_CELLS_LOG2 + 1);
    localparam logic [CNW-1:0] NONE = CNW'(MAX_CHUNKS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_POPW  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_ABS   = 4'd4;
    localparam logic [3:0] S_BUMP  = 4'd5;
    localparam logic [3:0] S_CLR   = 4'd6;
    localparam logic [3:0] S_RSCAN = 4'd7;
    localparam logic [3:0] S_SHR   = 4'd8;
    localparam logic [3:0] S_CRD   = 4'd9;
    localparam logic [3:0] S_CWR   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] cfg_cells_reg;
    logic [4:0] cfg_bytes_reg;

    logic [3:0]  state_reg;
    logic        pres_reg [MAX_CHUNKS];
    logic [BW-1:0] bump_reg [MAX_CHUNKS];
    logic [BW-1:0] live_reg [MAX_CHUNKS];
    logic [FW-1:0] free_reg;
    logic [CNW-1:0] cur_reg;
    logic [FW-1:0] used_reg;
    logic [CNW-1:0] npres_reg;

    logic [CNW-1:0] idx_reg;     // chunk walker
    logic [FW-1:0]  rd_reg;      // compaction read index
    logic [FW-1:0]  kept_reg;
    logic           any_reg;
    logic [cca_pkg::ID_W-1:0] id_reg;
    logic [1:0]     op_reg;
    logic [cca_pkg::ID_W-1:0] cid_reg;
    logic [1:0]     st_reg;
    logic [cca_pkg::REL_W-1:0] rel_reg;
    logic [CNW-1:0] sel_reg;
    logic           out_v_reg;

    logic [SW-1:0] sh;
    logic [BW-1:0] cells;
    logic [4:0]    blog;
    always_comb begin
        sh    = (cfg_cells_reg > 4'(MAX_CELLS_LOG2)) ? SW'(MAX_CELLS_LOG2)
                                                    : SW'(cfg_cells_reg);
        cells = BW'(1) << sh;
        blog  = (cfg_bytes_reg > 5'd30) ? 5'd30 : cfg_bytes_reg;
    end

    // stack memory
    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [cca_pkg::ID_W-1:0] wr_data, rd_data;
    cca_stack #(.DEPTH(DEPTH), .AW(AW)) u_stack (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic [cca_pkg::ID_W-1:0] rc_chunk_w;
    logic [cca_pkg::ID_W-1:0] pc_chunk_w;
    logic [CW-1:0] ix;
    logic          rc_ok_w;
    always_comb begin
        rc_chunk_w = cid_reg >> sh;
        pc_chunk_w = rd_data >> sh;
        ix         = idx_reg[CW-1:0];
        // recycle is accepted only for a present chunk with live cells and a stack with room
        rc_ok_w    = !(rc_chunk_w >= cca_pkg::ID_W'(MAX_CHUNKS) ||
                       !pres_reg[rc_chunk_w[CW-1:0]] ||
                       live_reg[rc_chunk_w[CW-1:0]] == '0 || free_reg >= FW'(DEPTH));
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = cid_reg;
        rd_addr = AW'(free_reg - FW'(1));
        if (state_reg == S_IDLE && s_axis_tvalid && !out_v_reg &&
            s_axis_tdata[1:0] == cca_pkg::OP_RECYCLE) begin
            rd_addr = '0;
        end
        if (state_reg == S_CRD || state_reg == S_CWR) begin
            rd_addr = AW'(rd_reg);
        end
        if (state_reg == S_POP && op_reg == cca_pkg::OP_RECYCLE && rc_ok_w) begin
            wr_en   = 1'b1;
            wr_addr = AW'(free_reg);
        end
        if (state_reg == S_CWR && (pc_chunk_w < cca_pkg::ID_W'(MAX_CHUNKS)) &&
            pres_reg[pc_chunk_w[CW-1:0]]) begin
            wr_en   = 1'b1;
            wr_addr = AW'(kept_reg);
            wr_data = rd_data;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {5'd0, rel_reg, 5'(npres_reg), 13'(used_reg), st_reg, id_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cells_reg <= 4'd8;
            cfg_bytes_reg <= 5'd16;
        end else if (cfg_wr_en) begin
            if (cfg_addr == 1'b0) cfg_cells_reg <= cfg_data[3:0];
            else                  cfg_bytes_reg <= cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            free_reg  <= '0;
            cur_reg   <= NONE;
            used_reg  <= '0;
            npres_reg <= '0;
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                pres_reg[i] <= 1'b0;
                bump_reg[i] <= '0;
                live_reg[i] <= '0;
            end
        end else begin
            if (out_v_reg && m_axis_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && !out_v_reg) begin
                        op_reg  <= s_axis_tdata[1:0];
                        cid_reg <= s_axis_tdata[13:2];
                        id_reg  <= '0;
                        st_reg  <= cca_pkg::ST_OK;
                        rel_reg <= '0;
                        idx_reg <= '0;
                        any_reg <= 1'b0;
                        case (s_axis_tdata[1:0])
                            cca_pkg::OP_ALLOC: begin
                                if (free_reg != '0) state_reg <= S_POPW;
                                else if (cur_reg < NONE && pres_reg[cur_reg[CW-1:0]] &&
                                         bump_reg[cur_reg[CW-1:0]] < cells) begin
                                    sel_reg   <= cur_reg;
                                    state_reg <= S_BUMP;
                                end else state_reg <= S_SCAN;
                            end
                            cca_pkg::OP_RECYCLE: state_reg <= S_POP;
                            cca_pkg::OP_RESET:   state_reg <= S_CLR;
                            default:             state_reg <= S_SHR;
                        endcase
                    end
                end
                S_POPW: begin
                    // stack read data arrives now
                    free_reg <= free_reg - FW'(1);
                    id_reg   <= rd_data;
                    if (pc_chunk_w < cca_pkg::ID_W'(MAX_CHUNKS) &&
                        live_reg[pc_chunk_w[CW-1:0]] < BW'(1 << MAX_CELLS_LOG2))
                        live_reg[pc_chunk_w[CW-1:0]] <= live_reg[pc_chunk_w[CW-1:0]] + BW'(1);
                    if (used_reg < FW'(DEPTH)) used_reg <= used_reg + FW'(1);
                    state_reg <= S_OUT;
                end
                S_POP: begin
                    // recycle check and push
                    if (!rc_ok_w) begin
                        st_reg <= cca_pkg::ST_INVALID;
                    end else begin
                        free_reg <= free_reg + FW'(1);
                        live_reg[rc_chunk_w[CW-1:0]] <= live_reg[rc_chunk_w[CW-1:0]] - BW'(1);
                        if (used_reg != '0) used_reg <= used_reg - FW'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_SCAN: begin
                    // first present chunk that is not full
                    if (idx_reg == NONE) begin
                        idx_reg   <= '0;
                        state_reg <= S_ABS;
                    end else if (pres_reg[ix] && bump_reg[ix] < cells) begin
                        sel_reg   <= idx_reg;
                        state_reg <= S_BUMP;
                    end else idx_reg <= idx_reg + CNW'(1);
                end
                S_ABS: begin
                    // lowest absent chunk
                    if (idx_reg == NONE) begin
                        cur_reg   <= NONE;
                        st_reg    <= cca_pkg::ST_NOSPACE;
                        state_reg <= S_OUT;
                    end else if (!pres_reg[ix]) begin
                        pres_reg[ix] <= 1'b1;
                        bump_reg[ix] <= '0;
                        live_reg[ix] <= '0;
                        npres_reg    <= npres_reg + CNW'(1);
                        sel_reg      <= idx_reg;
                        state_reg    <= S_BUMP;
                    end else idx_reg <= idx_reg + CNW'(1);
                end
                S_BUMP: begin
                    id_reg <= cca_pkg::ID_W'((cca_pkg::ID_W'(sel_reg) << sh) |
                                             cca_pkg::ID_W'(bump_reg[sel_reg[CW-1:0]]));
                    bump_reg[sel_reg[CW-1:0]] <= bump_reg[sel_reg[CW-1:0]] + BW'(1);
                    if (live_reg[sel_reg[CW-1:0]] < BW'(1 << MAX_CELLS_LOG2))
                        live_reg[sel_reg[CW-1:0]] <= live_reg[sel_reg[CW-1:0]] + BW'(1);
                    if (used_reg < FW'(DEPTH)) used_reg <= used_reg + FW'(1);
                    cur_reg <= (bump_reg[sel_reg[CW-1:0]] + BW'(1) >= cells) ? NONE : sel_reg;
                    state_reg <= S_OUT;
                end
                S_CLR: begin
                    free_reg <= '0;
                    used_reg <= '0;
                    for (int i = 0; i < MAX_CHUNKS; i++) begin
                        bump_reg[i] <= '0;
                        live_reg[i] <= '0;
                    end
                    state_reg <= S_RSCAN;
                end
                S_RSCAN: begin
                    // first present chunk after clear (bump is zero)
                    if (idx_reg == NONE) begin
                        cur_reg   <= NONE;
                        state_reg <= S_OUT;
                    end else if (pres_reg[ix]) begin
                        cur_reg   <= idx_reg;
                        state_reg <= S_OUT;
                    end else idx_reg <= idx_reg + CNW'(1);
                end
                S_SHR: begin
                    // release empty chunks, one per cycle
                    if (idx_reg == NONE) begin
                        rd_reg   <= '0;
                        kept_reg <= '0;
                        state_reg <= (any_reg && free_reg != '0) ? S_CRD : S_OUT;
                    end else begin
                        if (pres_reg[ix] && live_reg[ix] == '0) begin
                            pres_reg[ix] <= 1'b0;
                            bump_reg[ix] <= '0;
                            if (npres_reg != '0) npres_reg <= npres_reg - CNW'(1);
                            rel_reg <= rel_reg + (cca_pkg::REL_W'(1) << blog);
                            any_reg <= 1'b1;
                            if (cur_reg == idx_reg) cur_reg <= NONE;
                        end
                        idx_reg <= idx_reg + CNW'(1);
                    end
                end
                S_CRD: state_reg <= S_CWR;  // read of entry rd_reg in flight
                S_CWR: begin
                    // keep entries whose chunk is still present
                    if (wr_en) kept_reg <= kept_reg + FW'(1);
                    rd_reg <= rd_reg + FW'(1);
                    if (rd_reg + FW'(1) >= free_reg) begin
                        free_reg  <= kept_reg + FW'(wr_en);
                        state_reg <= S_OUT;
                    end else state_reg <= S_CRD;
                end
                S_OUT: begin
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/cca_stack.sv =====
// free stack memory, one write and one registered read per cycle
`timescale 1ns / 1ps
module cca_stack #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [cca_pkg::ID_W-1:0] wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic [cca_pkg::ID_W-1:0] rd_data
);
    logic [cca_pkg::ID_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== tb/sv/chunked_cell_allocator_unit_tb.sv =====
// testbench for the chunked cell allocator: random streams checked against a cell pool predictor
`timescale 1ns / 1ps
module chunked_cell_allocator_unit_tb;

    localparam int NCHUNK    = 16;
    localparam int CELLS_MAX = 8;
    localparam int STACK_D   = NCHUNK << CELLS_MAX;
    localparam logic REG_CELLS_LOG2 = 1'b0;
    localparam logic REG_BYTES_LOG2 = 1'b1;

    typedef struct packed {
        logic [cca_pkg::REL_W-1:0] released;
        logic [4:0]                chunks;
        logic [12:0]               used;
        logic [1:0]                status;
        logic [cca_pkg::ID_W-1:0]  id;
    } alloc_result_t;

    // cell pool predictor and store of expected result words
    class cell_pool_scoreboard;
        bit                       present [NCHUNK];
        int unsigned              bump [NCHUNK];
        int unsigned              live [NCHUNK];
        logic [cca_pkg::ID_W-1:0] stack_mem [STACK_D];
        int unsigned              free_n;
        int unsigned              cur;
        int unsigned              in_use;
        int unsigned              n_present;
        int unsigned              cells_log2;
        int unsigned              bytes_log2;
        alloc_result_t            expected_q [$];
        logic [cca_pkg::ID_W-1:0] handed_out [$];
        int                       errors;

        function new();
            for (int i = 0; i < NCHUNK; i++) begin
                present[i] = 0;
                bump[i] = 0;
                live[i] = 0;
            end
            free_n = 0;
            cur = NCHUNK;
            in_use = 0;
            n_present = 0;
            cells_log2 = 8;
            bytes_log2 = 16;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned shift_now();
            return cells_log2 > CELLS_MAX ? CELLS_MAX : cells_log2;
        endfunction

        function int unsigned first_open(int unsigned cells);
            for (int i = 0; i < NCHUNK; i++)
                if (present[i] && bump[i] < cells) return i;
            return NCHUNK;
        endfunction

        function void take_cell(int unsigned c);
            if (c < NCHUNK && live[c] < (1 << CELLS_MAX)) live[c]++;
            if (in_use < STACK_D) in_use++;
        endfunction

        function void write_reg(logic idx, logic [4:0] val);
            if (idx == REG_CELLS_LOG2) cells_log2 = val[3:0];
            else bytes_log2 = val;
        endfunction

        // predict the result of one accepted request word
        function void note_request(logic [1:0] op, logic [cca_pkg::ID_W-1:0] cid);
            alloc_result_t r;
            int unsigned sh, cells, c, blog;
            logic [63:0] rel;
            bit any;
            int unsigned kept;
            r = '0;
            sh = shift_now();
            cells = 1 << sh;
            rel = 0;
            case (op)
                cca_pkg::OP_ALLOC: begin
                    if (free_n > 0) begin
                        free_n--;
                        r.id = stack_mem[free_n];
                        take_cell(r.id >> sh);
                        handed_out.insert(handed_out.size(), r.id);
                    end else begin
                        c = cur;
                        if (c >= NCHUNK || !present[c] || bump[c] >= cells)
                            c = first_open(cells);
                        if (c == NCHUNK) begin
                            for (int i = NCHUNK - 1; i >= 0; i--)
                                if (!present[i]) c = i;
                        end
                        if (c == NCHUNK) begin
                            cur = NCHUNK;
                            r.status = cca_pkg::ST_NOSPACE;
                        end else begin
                            if (!present[c]) begin
                                present[c] = 1;
                                bump[c] = 0;
                                live[c] = 0;
                                n_present++;
                            end
                            r.id = cca_pkg::ID_W'((c << sh) | bump[c]);
                            bump[c]++;
                            take_cell(c);
                            cur = (bump[c] >= cells) ? NCHUNK : c;
                            handed_out.insert(handed_out.size(), r.id);
                        end
                    end
                end
                cca_pkg::OP_RECYCLE: begin
                    c = cid >> sh;
                    if (c >= NCHUNK || !present[c] || live[c] == 0 || free_n >= STACK_D)
                        r.status = cca_pkg::ST_INVALID;
                    else begin
                        stack_mem[free_n] = cid;
                        free_n++;
                        live[c]--;
                        if (in_use > 0) in_use--;
                    end
                end
                cca_pkg::OP_RESET: begin
                    free_n = 0;
                    for (int i = 0; i < NCHUNK; i++) begin
                        bump[i] = 0;
                        live[i] = 0;
                    end
                    in_use = 0;
                    cur = first_open(cells);
                    handed_out.delete();
                end
                default: begin
                    blog = bytes_log2 > 30 ? 30 : bytes_log2;
                    any = 0;
                    for (int i = 0; i < NCHUNK; i++) begin
                        if (present[i] && live[i] == 0) begin
                            present[i] = 0;
                            bump[i] = 0;
                            if (n_present > 0) n_present--;
                            rel += 64'd1 << blog;
                            any = 1;
                            if (cur == i) cur = NCHUNK;
                        end
                    end
                    // drop stack entries whose chunk went away
                    if (any && free_n > 0) begin
                        kept = 0;
                        for (int i = 0; i < free_n; i++) begin
                            c = stack_mem[i] >> sh;
                            if (c < NCHUNK && present[c]) begin
                                stack_mem[kept] = stack_mem[i];
                                kept++;
                            end
                        end
                        free_n = kept;
                    end
                end
            endcase
            r.used = in_use[12:0];
            r.chunks = n_present[4:0];
            r.released = rel[cca_pkg::REL_W-1:0];
            expected_q.insert(expected_q.size(), r);
        endfunction

        // compare one result word with the oldest expectation
        task check_result(logic [71:0] word);
            alloc_result_t got, exp;
            got = word[66:0];
            if (expected_q.size() == 0) begin
                report($sformatf("result word with nothing expected: %h", word));
                return;
            end
            exp = expected_q.pop_front();
            if (got.id !== exp.id)
                report($sformatf("allocated_id %h, expected %h", got.id, exp.id));
            if (got.status !== exp.status)
                report($sformatf("status %0d, expected %0d", got.status, exp.status));
            if (got.used !== exp.used)
                report($sformatf("used_cells %0d, expected %0d", got.used, exp.used));
            if (got.chunks !== exp.chunks)
                report($sformatf("live_chunks %0d, expected %0d", got.chunks, exp.chunks));
            if (got.released !== exp.released)
                report($sformatf("released_bytes %0d, expected %0d",
                                 got.released, exp.released));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // operation[1:0], cell_id[13:2], zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;    // allocated_id, status, used_cells, live_chunks,
                                  // released_bytes, zero
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [4:0]  cfg_data;

    cell_pool_scoreboard pool_sb = new();
    int burst_left = 0;
    int stall_mode = 0;
    int stall_cnt  = 0;

    chunked_cell_allocator_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // receiver stall pattern, switching between four randomly chosen modes
    always @(negedge aclk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt = 64;
        end
        stall_cnt--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
            2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= ((stall_cnt % 16) < 12);
        endcase
    end

    // result word monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            pool_sb.check_result(m_axis_tdata);
    end

    // send one request word; entered and left at a falling edge
    task send_word(logic [1:0] op, logic [cca_pkg::ID_W-1:0] cid);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, cid, op};
        do @(posedge aclk); while (!s_axis_tready);
        pool_sb.note_request(op, cid);
        burst_left--;
        @(negedge aclk);
    endtask

    // let every expected word come back, then some settle time
    task wait_idle();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pool_sb.expected_q.size() > 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task write_cfg(logic idx, logic [4:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        pool_sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // mostly well-formed alloc / recycle traffic with some noise
    task random_phase(int n);
        int pick, k;
        logic [cca_pkg::ID_W-1:0] cid;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 48) send_word(cca_pkg::OP_ALLOC, cca_pkg::ID_W'($urandom));
            else if (pick < 88) begin
                if (pool_sb.handed_out.size() > 0 && pick < 84) begin
                    k = $urandom_range(0, pool_sb.handed_out.size() - 1);
                    cid = pool_sb.handed_out[k];
                    pool_sb.handed_out.delete(k);
                end else
                    cid = cca_pkg::ID_W'($urandom);
                send_word(cca_pkg::OP_RECYCLE, cid);
            end else if (pick < 91) send_word(cca_pkg::OP_RESET, cca_pkg::ID_W'($urandom));
            else send_word(cca_pkg::OP_SHRINK, cca_pkg::ID_W'($urandom));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: defaults, invalid and zero-count recycles, reset and shrink
        send_word(cca_pkg::OP_ALLOC, 12'hfff);
        send_word(cca_pkg::OP_ALLOC, 12'h000);
        send_word(cca_pkg::OP_RECYCLE, 12'h001);
        send_word(cca_pkg::OP_RECYCLE, 12'hfff);
        send_word(cca_pkg::OP_RECYCLE, 12'h100);
        send_word(cca_pkg::OP_ALLOC, 12'h000);
        send_word(cca_pkg::OP_RESET, 12'h000);
        send_word(cca_pkg::OP_RECYCLE, 12'h000);
        send_word(cca_pkg::OP_SHRINK, 12'h000);
        send_word(cca_pkg::OP_SHRINK, 12'h000);
        wait_idle();
        // id pushed under a wide slot field comes back out of chunk range
        write_cfg(REG_CELLS_LOG2, 5'd4);
        write_cfg(REG_BYTES_LOG2, 5'd31);
        for (int i = 0; i < 17; i++) send_word(cca_pkg::OP_ALLOC, 12'h000);
        send_word(cca_pkg::OP_RECYCLE, 12'h010);
        wait_idle();
        write_cfg(REG_CELLS_LOG2, 5'd0);
        send_word(cca_pkg::OP_ALLOC, 12'h000);
        send_word(cca_pkg::OP_SHRINK, 12'h000);
        for (int i = 0; i < 17; i++) send_word(cca_pkg::OP_ALLOC, 12'h000);
        send_word(cca_pkg::OP_RECYCLE, 12'hfff);
        send_word(cca_pkg::OP_SHRINK, 12'h000);
        wait_idle();

        // random phases across register settings
        write_cfg(REG_CELLS_LOG2, 5'd15);
        write_cfg(REG_BYTES_LOG2, 5'd30);
        random_phase(120);
        wait_idle();
        write_cfg(REG_CELLS_LOG2, 5'd0);
        write_cfg(REG_BYTES_LOG2, 5'd12);
        random_phase(120);
        wait_idle();
        write_cfg(REG_CELLS_LOG2, 5'd2);
        write_cfg(REG_BYTES_LOG2, 5'd31);
        random_phase(150);
        wait_idle();
        write_cfg(REG_CELLS_LOG2, 5'd1);
        write_cfg(REG_BYTES_LOG2, 5'd20);
        random_phase(150);
        wait_idle();
        write_cfg(REG_CELLS_LOG2, 5'd8);
        write_cfg(REG_BYTES_LOG2, 5'd16);
        random_phase(130);
        wait_idle();

        if (pool_sb.expected_q.size() != 0)
            pool_sb.report("expected words left over");
        if (pool_sb.errors == 0)
            $display("chunked_cell_allocator_unit regression: pass");
        else
            $display("chunked_cell_allocator_unit regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("chunked_cell_allocator_unit regression: fail");
        $finish;
    end
endmodule
